// ===== sv/rtph_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared constants and types for the byte-serial RTP fixed header parser.
// ----------------------------------------------------------------------------
package rtph_pkg;

	localparam int unsigned CountWidth     = 16;
	localparam int unsigned MaxPacketBytes = 65535;
	localparam int unsigned MinHeaderBytes = 12;
	localparam int unsigned HdrSizeWidth   = 19;
	localparam int unsigned InDataWidth    = 8;
	localparam int unsigned OutDataWidth   = 136;

	// Per-packet capture state.
	typedef struct packed {
		logic [7:0]            first;
		logic [7:0]            second;
		logic [15:0]           seq;
		logic [31:0]           ts;
		logic [31:0]           ssrc;
		logic [15:0]           ext_words;
		logic [1:0]            ext_seen;
		logic [CountWidth-1:0] count;
	} capture_t;

	// One parsed header summary.
	typedef struct packed {
		logic                    status;
		logic [1:0]              version;
		logic                    padding_flag;
		logic                    extension_flag;
		logic [3:0]              csrc_count;
		logic                    marker;
		logic [6:0]              media_type;
		logic [15:0]             sequence_number;
		logic [31:0]             timestamp;
		logic [31:0]             ssrc;
		logic [HdrSizeWidth-1:0] hdr_len;
		logic [15:0]             body_len;
	} result_t;

endpackage

// ===== sv/rtph_calc.sv =====
// ----------------------------------------------------------------------------
// RTP header size and status calculation
// Derives header size, payload size and the short-packet status from the
// capture state that includes the final byte of a packet.
// ----------------------------------------------------------------------------
module rtph_calc (
	input  rtph_pkg::capture_t cap,
	output rtph_pkg::result_t  res
);

	logic [rtph_pkg::HdrSizeWidth-1:0] hsize;
	logic [rtph_pkg::HdrSizeWidth-1:0] size;
	logic                              short_pkt;

	always_comb begin
		size = rtph_pkg::HdrSizeWidth'(cap.count);
		hsize = rtph_pkg::HdrSizeWidth'(rtph_pkg::MinHeaderBytes)
			+ rtph_pkg::HdrSizeWidth'({cap.first[3:0], 2'b00});
		short_pkt = (cap.count < rtph_pkg::CountWidth'(rtph_pkg::MinHeaderBytes));
		if (cap.first[4]) begin
			hsize = hsize + rtph_pkg::HdrSizeWidth'(4);
			if (cap.ext_seen >= 2'd2) begin
				hsize = hsize + rtph_pkg::HdrSizeWidth'({cap.ext_words, 2'b00});
			end else begin
				short_pkt = 1'b1;
			end
		end
		if (size < hsize) begin
			short_pkt = 1'b1;
		end

		res.status          = short_pkt;
		res.version         = cap.first[7:6];
		res.padding_flag    = cap.first[5];
		res.extension_flag  = cap.first[4];
		res.csrc_count      = cap.first[3:0];
		res.marker          = cap.second[7];
		res.media_type      = cap.second[6:0];
		res.sequence_number = cap.seq;
		res.timestamp       = cap.ts;
		res.ssrc            = cap.ssrc;
		res.hdr_len         = hsize;
		res.body_len        = short_pkt ? 16'd0 : 16'(size - hsize);
	end

endmodule

// ===== sv/rtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// RTP fixed header parser
// Takes an RTP packet one byte per word and, on the final byte, reports the
// fixed header fields, header size, payload size and a short-packet status.
//
// Channel  Direction  Word                          Marks
// s_*      in         one packet byte (tdata[7:0])  tlast on the final byte
// m_*      out        one header summary per packet tuser = short status
//
// One byte is taken every cycle while no final byte waits. A byte passes an
// input register, then the capture and size logic load the capture state
// and, on the final byte, the result register. While the result register
// is full and not taken, the final byte of the next packet waits in the
// input register; other bytes keep flowing. Reset clears all capture state
// and both valid flags.
// ----------------------------------------------------------------------------
module rtp_header_parser #(
	parameter int unsigned MAX_PACKET_BYTES = rtph_pkg::MaxPacketBytes
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rtph_pkg::InDataWidth-1:0]  s_tdata,  // [7:0] data_byte
	input  logic                              s_tlast,  // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] version, [2] padding_flag, [3] extension_flag, [7:4] csrc_count,
	// [8] marker, [15:9] media_type, [31:16] sequence_number,
	// [63:32] timestamp, [95:64] ssrc, [114:96] hdr_len,
	// [130:115] body_len, [135:131] zero
	output logic [rtph_pkg::OutDataWidth-1:0] m_tdata,
	output logic                              m_tuser   // [0] status
);

	localparam logic [rtph_pkg::CountWidth-1:0] MaxCount =
		rtph_pkg::CountWidth'(MAX_PACKET_BYTES);

	logic                             valid_s1;
	logic [rtph_pkg::InDataWidth-1:0] data_s1;
	logic                             last_s1;

	rtph_pkg::capture_t cap_q;
	rtph_pkg::capture_t cap_nxt;
	rtph_pkg::result_t  res_calc;
	rtph_pkg::result_t  res_q;
	logic               m_valid_q;

	logic                            out_free;
	logic                            go_s1;
	logic [rtph_pkg::CountWidth-1:0] ext_base;

	assign out_free = !m_valid_q || m_tready;
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Capture the byte at its packet position; bytes past the size limit are
	// only counted up to the limit and otherwise ignored.
	always_comb begin
		cap_nxt  = cap_q;
		ext_base = rtph_pkg::CountWidth'(rtph_pkg::MinHeaderBytes)
			+ rtph_pkg::CountWidth'({cap_q.first[3:0], 2'b00});
		if (cap_q.count < MaxCount) begin
			if (cap_q.count == 16'd0) begin
				cap_nxt.first = data_s1;
			end else if (cap_q.count == 16'd1) begin
				cap_nxt.second = data_s1;
			end else if (cap_q.count < 16'd4) begin
				cap_nxt.seq = {cap_q.seq[7:0], data_s1};
			end else if (cap_q.count < 16'd8) begin
				cap_nxt.ts = {cap_q.ts[23:0], data_s1};
			end else if (cap_q.count < 16'd12) begin
				cap_nxt.ssrc = {cap_q.ssrc[23:0], data_s1};
			end
			// The extension length sits after the profile field of the
			// extension header, which follows the CSRC list.
			if (cap_q.count >= 16'd12 && cap_q.first[4]) begin
				if (cap_q.count == ext_base + 16'd2) begin
					cap_nxt.ext_words = {data_s1, 8'h00};
					cap_nxt.ext_seen  = 2'd1;
				end else if (cap_q.count == ext_base + 16'd3) begin
					cap_nxt.ext_words = {cap_q.ext_words[15:8], data_s1};
					cap_nxt.ext_seen  = 2'd2;
				end
			end
			cap_nxt.count = cap_q.count + 16'd1;
		end
	end

	rtph_calc u_calc (
		.cap (cap_nxt),
		.res (res_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (go_s1) begin
				cap_q <= last_s1 ? '0 : cap_nxt;
			end
			if (go_s1 && last_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res_calc;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {
		5'd0,
		res_q.body_len,
		res_q.hdr_len,
		res_q.ssrc,
		res_q.timestamp,
		res_q.sequence_number,
		res_q.media_type,
		res_q.marker,
		res_q.csrc_count,
		res_q.extension_flag,
		res_q.padding_flag,
		res_q.version
	};

endmodule
